### sv/u8sd_pkg.sv
// ----------------------------------------------------------------------------
// u8sd_pkg
// Shared types and constants for the UTF-8 stream decoder: the classified
// byte command that the front end hands to the back end, and the code
// constants both sides use.
// ----------------------------------------------------------------------------
package u8sd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned CP_W   = 21;

  // Command queue between classifier and decoder
  localparam int unsigned CMD_DEPTH = 4;
  localparam int unsigned CMD_PTR_W = $clog2(CMD_DEPTH);
  localparam int unsigned CMD_CNT_W = $clog2(CMD_DEPTH + 1);

  localparam logic [CP_W-1:0]   REPLACEMENT_CP = 21'h00FFFD;
  localparam logic [CP_W-1:0]   MAX_SCALAR     = 21'h10FFFF;
  localparam logic [BYTE_W-1:0] MIN_LEAD2      = 8'hC2;

  typedef enum logic [1:0] {
    CMD_ASCII    = 2'd0,  // 00..7F
    CMD_LEAD     = 2'd1,  // valid 2/3/4-byte lead
    CMD_BAD_LEAD = 2'd2,  // C0, C1, F8..FF
    CMD_CONT     = 2'd3   // 80..BF
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [6:0]  data;   // ASCII value, lead payload or 6 continuation bits
    logic [1:0]  cnt;    // continuation bytes due after a lead
  } cmd_t;

endpackage

### sv/utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_unit
// Data path: an accepted byte is written to the command queue; the decoder
//   takes it and writes any result to the output buffer, read at the ports.
// Throughput: one byte per cycle while the command queue is not full.
// Reset (rst_n low, synchronous) empties both queues and clears the
//   partial code point and continuation count.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [u8sd_pkg::BYTE_W-1:0]  in_byte_in,
  output logic                         empty,
  input  logic                         pop,
  output logic [u8sd_pkg::CP_W-1:0]    out_code_point,
  output logic                         out_bad_sequence
);

  u8sd_pkg::cmd_t wr_cmd, rd_cmd;
  logic           cmd_wr, cmd_empty, cmd_take;

  u8sd_front u_front (
    .push       (push),
    .full       (full),
    .in_byte_in (in_byte_in),
    .cmd_wr     (cmd_wr),
    .cmd        (wr_cmd)
  );

  u8sd_cmd_fifo u_cmd_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (cmd_wr),
    .wr_cmd (wr_cmd),
    .full   (full),
    .rd_en  (cmd_take),
    .rd_cmd (rd_cmd),
    .empty  (cmd_empty)
  );

  u8sd_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_valid        (!cmd_empty),
    .cmd              (rd_cmd),
    .cmd_take         (cmd_take),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence),
    .empty            (empty),
    .pop              (pop)
  );

endmodule

### sv/u8sd_front.sv
// ----------------------------------------------------------------------------
// u8sd_front
// Byte classifier. Sorts each accepted byte into ASCII, lead, bad lead or
// continuation and strips the marker bits, producing one queue command.
// ----------------------------------------------------------------------------
module u8sd_front (
  input  logic                       push,
  input  logic                       full,
  input  logic [u8sd_pkg::BYTE_W-1:0] in_byte_in,
  output logic                       cmd_wr,
  output u8sd_pkg::cmd_t             cmd
);

  assign cmd_wr = push && !full;

  always_comb begin
    cmd.kind = u8sd_pkg::CMD_BAD_LEAD;
    cmd.data = 7'd0;
    cmd.cnt  = 2'd0;
    if (!in_byte_in[7]) begin
      cmd.kind = u8sd_pkg::CMD_ASCII;
      cmd.data = in_byte_in[6:0];
    end else if (in_byte_in[7:6] == 2'b10) begin
      cmd.kind = u8sd_pkg::CMD_CONT;
      cmd.data = {1'b0, in_byte_in[5:0]};
    end else if (in_byte_in[7:5] == 3'b110) begin
      // C0/C1 would only encode ASCII values
      if (in_byte_in >= u8sd_pkg::MIN_LEAD2) begin
        cmd.kind = u8sd_pkg::CMD_LEAD;
        cmd.data = {2'b00, in_byte_in[4:0]};
        cmd.cnt  = 2'd1;
      end
    end else if (in_byte_in[7:4] == 4'b1110) begin
      cmd.kind = u8sd_pkg::CMD_LEAD;
      cmd.data = {3'b000, in_byte_in[3:0]};
      cmd.cnt  = 2'd2;
    end else if (in_byte_in[7:3] == 5'b11110) begin
      cmd.kind = u8sd_pkg::CMD_LEAD;
      cmd.data = {4'b0000, in_byte_in[2:0]};
      cmd.cnt  = 2'd3;
    end
  end

endmodule

### sv/u8sd_cmd_fifo.sv
// ----------------------------------------------------------------------------
// u8sd_cmd_fifo
// Short command queue decoupling the classifier from the decoder.
// ----------------------------------------------------------------------------
module u8sd_cmd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  u8sd_pkg::cmd_t wr_cmd,
  output logic           full,
  input  logic           rd_en,
  output u8sd_pkg::cmd_t rd_cmd,
  output logic           empty
);

  u8sd_pkg::cmd_t                       mem_r [u8sd_pkg::CMD_DEPTH];
  logic [u8sd_pkg::CMD_PTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [u8sd_pkg::CMD_PTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [u8sd_pkg::CMD_CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                                 do_wr, do_rd;

  localparam logic [u8sd_pkg::CMD_CNT_W-1:0] DEPTH_C =
    u8sd_pkg::CMD_CNT_W'(u8sd_pkg::CMD_DEPTH);
  localparam logic [u8sd_pkg::CMD_PTR_W-1:0] LAST_C =
    u8sd_pkg::CMD_PTR_W'(u8sd_pkg::CMD_DEPTH - 1);

  assign full   = (cnt_r == DEPTH_C);
  assign empty  = (cnt_r == '0);
  assign rd_cmd = mem_r[rd_ptr_r];
  assign do_wr  = wr_en && !full;
  assign do_rd  = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_C) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_C) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_cmd;
    end
  end

endmodule

### sv/u8sd_back.sv
// ----------------------------------------------------------------------------
// u8sd_back
// Decoder proper: holds the partial code point and the count of
// continuation bytes due, executes one command per cycle while its output
// buffer is not full and queues the results in that two-entry buffer.
// ----------------------------------------------------------------------------
module u8sd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cmd_valid,
  input  u8sd_pkg::cmd_t               cmd,
  output logic                         cmd_take,
  output logic [u8sd_pkg::CP_W-1:0]    out_code_point,
  output logic                         out_bad_sequence,
  output logic                         empty,
  input  logic                         pop
);

  logic [u8sd_pkg::CP_W-1:0] pv_r, pv_nxt;
  logic [1:0]                br_r, br_nxt;

  logic [u8sd_pkg::CP_W-1:0] ob_cp_r  [2];
  logic                      ob_bad_r [2];
  logic                      ob_wr_r, ob_rd_r;
  logic [1:0]                ob_cnt_r, ob_cnt_nxt;

  logic                      emit, emit_bad;
  logic [u8sd_pkg::CP_W-1:0] emit_cp, shifted;
  logic                      ob_push, ob_pop;

  assign cmd_take = cmd_valid && (ob_cnt_r != 2'd2);
  assign shifted  = {pv_r[14:0], cmd.data[5:0]};

  always_comb begin
    pv_nxt   = pv_r;
    br_nxt   = br_r;
    emit     = 1'b0;
    emit_bad = 1'b0;
    emit_cp  = u8sd_pkg::REPLACEMENT_CP;
    case (cmd.kind)
      u8sd_pkg::CMD_ASCII: begin
        pv_nxt  = '0;
        br_nxt  = 2'd0;
        emit    = 1'b1;
        emit_cp = {14'd0, cmd.data};
      end
      u8sd_pkg::CMD_LEAD: begin
        // a pending sequence is dropped without a result
        pv_nxt = {14'd0, cmd.data};
        br_nxt = cmd.cnt;
      end
      u8sd_pkg::CMD_BAD_LEAD: begin
        br_nxt   = 2'd0;
        emit     = 1'b1;
        emit_bad = 1'b1;
      end
      u8sd_pkg::CMD_CONT: begin
        if (br_r == 2'd0) begin
          emit     = 1'b1;
          emit_bad = 1'b1;
        end else begin
          br_nxt = br_r - 2'd1;
          pv_nxt = shifted;
          if (br_r == 2'd1) begin
            pv_nxt = '0;
            emit   = 1'b1;
            if (shifted > u8sd_pkg::MAX_SCALAR) begin
              emit_bad = 1'b1;
            end else begin
              emit_cp = shifted;
            end
          end
        end
      end
      default: begin
        br_nxt = br_r;
      end
    endcase
  end

  assign ob_push = cmd_take && emit;
  assign ob_pop  = pop && (ob_cnt_r != 2'd0);

  always_comb begin
    ob_cnt_nxt = ob_cnt_r;
    if (ob_push && !ob_pop) begin
      ob_cnt_nxt = ob_cnt_r + 2'd1;
    end else if (ob_pop && !ob_push) begin
      ob_cnt_nxt = ob_cnt_r - 2'd1;
    end
  end

  assign empty            = (ob_cnt_r == 2'd0);
  assign out_code_point   = ob_cp_r[ob_rd_r];
  assign out_bad_sequence = ob_bad_r[ob_rd_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r     <= '0;
      br_r     <= 2'd0;
      ob_wr_r  <= 1'b0;
      ob_rd_r  <= 1'b0;
      ob_cnt_r <= 2'd0;
    end else begin
      if (cmd_take) begin
        pv_r <= pv_nxt;
        br_r <= br_nxt;
      end
      if (ob_push) begin
        ob_wr_r <= ~ob_wr_r;
      end
      if (ob_pop) begin
        ob_rd_r <= ~ob_rd_r;
      end
      ob_cnt_r <= ob_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ob_push) begin
      ob_cp_r[ob_wr_r]  <= emit_cp;
      ob_bad_r[ob_wr_r] <= emit_bad;
    end
  end

  a_ob_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ob_cnt_r != 2'd3)
    else $error("output buffer count overflow");

  a_bad_is_repl: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_bad_sequence) |-> (out_code_point == u8sd_pkg::REPLACEMENT_CP))
    else $error("bad result without replacement code point");

  a_ascii_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && cmd.kind == u8sd_pkg::CMD_ASCII) |=> (br_r == 2'd0))
    else $error("ASCII byte left a sequence pending");

  a_lead_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_take && cmd.kind == u8sd_pkg::CMD_LEAD) |=> (br_r == $past(cmd.cnt)))
    else $error("lead byte did not load continuation count");

endmodule

### tb/sv/tb_utf8_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_unit
// Self-checking bench for the byte-serial UTF-8 decoder. A directed byte
// stream exercises ASCII limits, bad leads, stray continuations, dropped and
// interrupted sequences, overlong and surrogate forms, and values past the
// Unicode range. Random complete sequences, truncated ones and noise bytes
// follow. Each accepted byte runs through a local decoder model, and every
// popped scalar is compared against the oldest predicted one.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RAND_BYTES = 950;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [u8sd_pkg::CP_W-1:0] cp;
    logic                      bad;
  } scalar_t;

  typedef struct packed {
    logic                        pause_mark;  // sender holds until all results are back
    logic [u8sd_pkg::BYTE_W-1:0] value;
  } stream_item_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        push = 1'b0;
  logic                        full;
  logic [u8sd_pkg::BYTE_W-1:0] in_byte_in = '0;
  logic                        empty;
  logic                        pop = 1'b0;
  logic [u8sd_pkg::CP_W-1:0]   out_code_point;
  logic                        out_bad_sequence;

  utf8_stream_decoder_unit u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_byte_in       (in_byte_in),
    .empty            (empty),
    .pop              (pop),
    .out_code_point   (out_code_point),
    .out_bad_sequence (out_bad_sequence)
  );

  stream_item_t              byte_q[$];
  scalar_t                   scalar_q[$];
  logic [u8sd_pkg::CP_W-1:0] partial_cp = '0;
  logic [1:0]                conts_due = '0;
  logic                      byte_taken = 1'b0;
  int unsigned               fail_count = 0;
  int unsigned               cycle_cnt = 0;
  int unsigned               byte_count = 0;
  int unsigned               burst_left = 0;
  int unsigned               gap_left = 0;
  int unsigned               pop_mode = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder model: one byte in, zero or one scalar appended to scalar_q
  // --------------------------------------------------------------------------
  task automatic decode_byte(input logic [u8sd_pkg::BYTE_W-1:0] b);
    u8sd_pkg::cmd_kind_t       kind;
    logic [u8sd_pkg::CP_W-1:0] done_cp;
    if (b < 8'h80)
      kind = u8sd_pkg::CMD_ASCII;
    else if (b[7:6] == 2'b10)
      kind = u8sd_pkg::CMD_CONT;
    else if (b >= u8sd_pkg::MIN_LEAD2 && b < 8'hF8)
      kind = u8sd_pkg::CMD_LEAD;
    else
      kind = u8sd_pkg::CMD_BAD_LEAD;

    case (kind)
      u8sd_pkg::CMD_ASCII: begin
        partial_cp = '0;
        conts_due  = '0;
        scalar_q.push_back('{cp: u8sd_pkg::CP_W'(b), bad: 1'b0});
      end
      u8sd_pkg::CMD_LEAD: begin
        // a pending sequence is dropped without a result
        if (b[7:5] == 3'b110) begin
          partial_cp = u8sd_pkg::CP_W'(b[4:0]);
          conts_due  = 2'd1;
        end else if (b[7:4] == 4'hE) begin
          partial_cp = u8sd_pkg::CP_W'(b[3:0]);
          conts_due  = 2'd2;
        end else begin
          partial_cp = u8sd_pkg::CP_W'(b[2:0]);
          conts_due  = 2'd3;
        end
      end
      u8sd_pkg::CMD_BAD_LEAD: begin
        conts_due = '0;
        scalar_q.push_back('{cp: u8sd_pkg::REPLACEMENT_CP, bad: 1'b1});
      end
      default: begin
        if (conts_due == 2'd0) begin
          scalar_q.push_back('{cp: u8sd_pkg::REPLACEMENT_CP, bad: 1'b1});
        end else begin
          partial_cp = {partial_cp[u8sd_pkg::CP_W-7:0], b[5:0]};
          conts_due  = conts_due - 2'd1;
          if (conts_due == 2'd0) begin
            done_cp    = partial_cp;
            partial_cp = '0;
            if (done_cp > u8sd_pkg::MAX_SCALAR)
              scalar_q.push_back('{cp: u8sd_pkg::REPLACEMENT_CP, bad: 1'b1});
            else
              scalar_q.push_back('{cp: done_cp, bad: 1'b0});
          end
        end
      end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Monitor: input acceptance feeds the model, output transactions are checked
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    scalar_t want;
    if (!rst_n) begin
      byte_taken <= 1'b0;
    end else begin
      byte_taken <= push && !full;
      if (push && !full)
        decode_byte(in_byte_in);
      if (pop && !empty) begin
        if (scalar_q.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("ERROR: unexpected result cp=%06h bad=%0b",
                     out_code_point, out_bad_sequence);
          fail_count++;
        end else begin
          want = scalar_q.pop_front();
          if (out_code_point !== want.cp || out_bad_sequence !== want.bad) begin
            if (fail_count < MAX_REPORTS)
              $display("ERROR: cp exp=%06h got=%06h  bad exp=%0b got=%0b",
                       want.cp, out_code_point, want.bad, out_bad_sequence);
            fail_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: bursts of bytes with random gaps; pause marks wait for drain
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else if (push && !byte_taken) begin
      // transaction still pending, hold
    end else if (gap_left != 0) begin
      gap_left--;
      push <= 1'b0;
    end else if (byte_q.size() == 0) begin
      push <= 1'b0;
    end else if (byte_q[0].pause_mark) begin
      push <= 1'b0;
      if (scalar_q.size() == 0)
        void'(byte_q.pop_front());
    end else begin
      in_byte_in <= byte_q[0].value;
      push       <= 1'b1;
      void'(byte_q.pop_front());
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      end else begin
        burst_left--;
      end
    end
  end

  // receiver stall pattern, re-chosen whenever the low six bits of cycle_cnt are zero
  always @(negedge clk) begin
    if (cycle_cnt[5:0] == 6'd0)
      pop_mode = $urandom_range(0, 3);
    case (pop_mode)
      0:       pop <= 1'b1;
      1:       pop <= 1'($urandom_range(0, 1));
      2:       pop <= (cycle_cnt[1:0] == 2'd0);
      default: pop <= (cycle_cnt[4:3] != 2'd0);
    endcase
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("utf8_stream_decoder_unit verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void add_byte(input logic [u8sd_pkg::BYTE_W-1:0] b);
    byte_q.push_back('{pause_mark: 1'b0, value: b});
    byte_count++;
  endfunction

  function automatic void add_pause();
    byte_q.push_back('{pause_mark: 1'b1, value: '0});
  endfunction

  function automatic logic [u8sd_pkg::BYTE_W-1:0] rand_cont();
    return u8sd_pkg::BYTE_W'($urandom_range(8'h80, 8'hBF));
  endfunction

  function automatic logic [u8sd_pkg::BYTE_W-1:0] rand_lead(input int unsigned len);
    case (len)
      2:       return u8sd_pkg::BYTE_W'($urandom_range(8'hC2, 8'hDF));
      3:       return u8sd_pkg::BYTE_W'($urandom_range(8'hE0, 8'hEF));
      default: return ($urandom_range(0, 3) == 0)
                        ? u8sd_pkg::BYTE_W'($urandom_range(8'hF5, 8'hF7))
                        : u8sd_pkg::BYTE_W'($urandom_range(8'hF0, 8'hF4));
    endcase
  endfunction

  initial begin
    int unsigned sel;
    int unsigned len;
    int unsigned n_cont;
    bit          mid_pause_done;
    mid_pause_done = 1'b0;

    // ASCII limits, all bad lead groups, stray continuation
    add_byte(8'h00); add_byte(8'h7F);
    add_byte(8'hC0); add_byte(8'hC1); add_byte(8'hF8); add_byte(8'hFF);
    add_byte(8'h80);
    // lead dropped by a new lead, then a 2-byte sequence
    add_byte(8'hE2); add_byte(8'hC3); add_byte(8'hA9);
    // sequence cut short by ASCII
    add_byte(8'hE2); add_byte(8'h41);
    // overlong 3-byte, surrogate
    add_byte(8'hE0); add_byte(8'h80); add_byte(8'h80);
    add_byte(8'hED); add_byte(8'hA0); add_byte(8'h80);
    // top of range, then past it
    add_byte(8'hF4); add_byte(8'h8F); add_byte(8'hBF); add_byte(8'hBF);
    add_byte(8'hF7); add_byte(8'hBF); add_byte(8'hBF); add_byte(8'hBF);
    add_pause();

    byte_count = 0;
    while (byte_count < RAND_BYTES) begin
      if (!mid_pause_done && byte_count > RAND_BYTES / 2) begin
        add_pause();
        mid_pause_done = 1'b1;
      end
      sel = $urandom_range(0, 99);
      if (sel < 25) begin
        add_byte(u8sd_pkg::BYTE_W'($urandom_range(0, 8'h7F)));
      end else if (sel < 82) begin
        len = (sel < 45) ? 2 : (sel < 65) ? 3 : 4;
        add_byte(rand_lead(len));
        repeat (len - 1) add_byte(rand_cont());
      end else if (sel < 90) begin
        // truncated sequence
        len    = $urandom_range(2, 4);
        n_cont = $urandom_range(0, len - 2);
        add_byte(rand_lead(len));
        repeat (n_cont) add_byte(rand_cont());
      end else begin
        add_byte(u8sd_pkg::BYTE_W'($urandom_range(0, 255)));
      end
    end

    rst_n <= 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || push || scalar_q.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);

    if (fail_count == 0) begin
      $display("utf8_stream_decoder_unit verification clean");
    end else begin
      $display("utf8_stream_decoder_unit verification failed");
    end
    $finish;
  end

endmodule
